@@ design/gpd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the grid position de-duplication block.
// No dependencies.
package gpd_pkg;

  localparam int unsigned GRID_MAX_BITS = 16;
  localparam int unsigned TRACE_BITS    = 16;
  localparam int unsigned APB_AW        = 5;
  localparam int unsigned APB_DW        = 32;

  typedef enum logic [2:0] {
    REG_APERTURE_LO_X = 3'd0,
    REG_APERTURE_HI_X = 3'd1,
    REG_APERTURE_LO_Y = 3'd2,
    REG_APERTURE_HI_Y = 3'd3,
    REG_ORIGIN_X      = 3'd4,
    REG_ORIGIN_Y      = 3'd5,
    REG_INV_STEP_X    = 3'd6,
    REG_INV_STEP_Y    = 3'd7
  } gpd_reg_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIFF,
    F_MUL_X,
    F_MUL_Y,
    F_PUSH
  } gpd_fstate_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DONE
  } gpd_bstate_e;

  typedef struct packed {
    logic                  start_new_list;
    logic signed [31:0]    shot_x;
    logic signed [31:0]    shot_y;
    logic [TRACE_BITS-1:0] trace_count;
  } gpd_in_t;

  typedef struct packed {
    logic        inside_aperture;
    logic        added_new;
    logic        table_full;
    logic        off_grid;
    logic [9:0]  slot;
    logic [11:0] grid_x;
    logic [11:0] grid_y;
    logic [10:0] list_size;
    logic [23:0] slot_count;
  } gpd_out_t;

  typedef struct packed {
    logic signed [31:0] aperture_lo_x;
    logic signed [31:0] aperture_hi_x;
    logic signed [31:0] aperture_lo_y;
    logic signed [31:0] aperture_hi_y;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [31:0]        inv_step_x;
    logic [31:0]        inv_step_y;
  } gpd_cfg_t;

  typedef struct packed {
    logic                     start;
    logic                     in_aper;
    logic                     off_grid;
    logic [GRID_MAX_BITS-1:0] gx;
    logic [GRID_MAX_BITS-1:0] gy;
    logic [TRACE_BITS-1:0]    trace_count;
  } gpd_cls_t;

endpackage

@@ design/gpd_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts shots, tests the aperture and snaps them to grid indices.
// Depends on gpd_pkg.
module gpd_front import gpd_pkg::*; #(
  parameter int unsigned GRID_BITS = 12
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  gpd_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gpd_in_t  in_data_i,
  output logic     q_push_o,
  output gpd_cls_t q_data_o,
  input  logic     q_full_i
);

  localparam logic [32:0] GMAX = 33'((64'd1 << GRID_BITS) - 64'd1);

  gpd_fstate_e state_q, state_d;
  gpd_in_t     item_q;
  logic [31:0] mag_x_q, mag_y_q;
  logic        neg_x_q, neg_y_q, in_aper_q;
  logic [63:0] prod_q;
  logic [GRID_BITS-1:0] gx_q;
  logic        clamp_x_q;

  logic [32:0] dx, dy, mx, my;
  logic        in_aper;
  logic [GRID_BITS:0] snap_x, snap_y;

  function automatic logic [GRID_BITS:0] snap_f(input logic [63:0] prod, input logic neg);
    logic [32:0]        r;
    logic [GRID_BITS:0] res;
    r = {1'b0, prod[63:32]} + {32'd0, prod[31]};
    if (neg && r != 33'd0) begin
      res = {1'b1, {GRID_BITS{1'b0}}};
    end else if (r > GMAX) begin
      res = {1'b1, GMAX[GRID_BITS-1:0]};
    end else begin
      res = {1'b0, r[GRID_BITS-1:0]};
    end
    return res;
  endfunction

  always_comb begin
    dx = {item_q.shot_x[31], item_q.shot_x} - {cfg_i.origin_x[31], cfg_i.origin_x};
    dy = {item_q.shot_y[31], item_q.shot_y} - {cfg_i.origin_y[31], cfg_i.origin_y};
    mx = dx[32] ? (~dx + 33'd1) : dx;
    my = dy[32] ? (~dy + 33'd1) : dy;
    in_aper = (item_q.shot_x >= cfg_i.aperture_lo_x) && (item_q.shot_x <= cfg_i.aperture_hi_x) &&
              (item_q.shot_y >= cfg_i.aperture_lo_y) && (item_q.shot_y <= cfg_i.aperture_hi_y);
    snap_x = snap_f(prod_q, neg_x_q);
    snap_y = snap_f(prod_q, neg_y_q);
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = (state_q != F_IDLE);
    q_push_o   = 1'b0;
    q_data_o.start       = item_q.start_new_list;
    q_data_o.in_aper     = in_aper_q;
    q_data_o.off_grid    = clamp_x_q | snap_y[GRID_BITS];
    q_data_o.gx          = GRID_MAX_BITS'(gx_q);
    q_data_o.gy          = GRID_MAX_BITS'(snap_y[GRID_BITS-1:0]);
    q_data_o.trace_count = item_q.trace_count;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) state_d = F_DIFF;
      end
      F_DIFF:  state_d = F_MUL_X;
      F_MUL_X: state_d = F_MUL_Y;
      F_MUL_Y: state_d = F_PUSH;
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      item_q <= in_data_i;
    end
    if (state_q == F_DIFF) begin
      mag_x_q   <= mx[31:0];
      mag_y_q   <= my[31:0];
      neg_x_q   <= dx[32];
      neg_y_q   <= dy[32];
      in_aper_q <= in_aper;
    end
    if (state_q == F_MUL_X) begin
      prod_q <= mag_x_q * cfg_i.inv_step_x;
    end
    if (state_q == F_MUL_Y) begin
      prod_q    <= mag_y_q * cfg_i.inv_step_y;
      gx_q      <= snap_x[GRID_BITS-1:0];
      clamp_x_q <= snap_x[GRID_BITS];
    end
  end

endmodule

@@ design/gpd_queue.sv @@
`timescale 1ns / 1ps
// Two-entry queue of classified shots between front and back end.
// Depends on gpd_pkg.
module gpd_queue import gpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  gpd_cls_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output gpd_cls_t pop_data_o,
  output logic     empty_o
);

  gpd_cls_t   slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2) else $error("queue count overrun");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("pop from empty queue");

endmodule

@@ design/gpd_back.sv @@
`timescale 1ns / 1ps
// Back end: scans the position list, appends or accumulates, drives results.
// Depends on gpd_pkg.
module gpd_back import gpd_pkg::*; #(
  parameter int unsigned MAX_POSITIONS = 1024,
  parameter int unsigned GRID_BITS     = 12,
  parameter int unsigned COUNT_BITS    = 24
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  gpd_cls_t q_data_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gpd_out_t out_data_o
);

  localparam int unsigned AW = $clog2(MAX_POSITIONS);
  localparam int unsigned UW = $clog2(MAX_POSITIONS + 1);
  localparam int unsigned MW = 2 * GRID_BITS + COUNT_BITS;
  localparam int unsigned SW = ((COUNT_BITS > TRACE_BITS) ? COUNT_BITS : TRACE_BITS) + 1;
  localparam logic [SW-1:0] CMAX = SW'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [UW-1:0] UMAX = UW'(MAX_POSITIONS);

  logic [MW-1:0] mem_q [MAX_POSITIONS];
  logic [MW-1:0] rd_data_q;

  gpd_bstate_e state_q, state_d;
  gpd_cls_t    cur_q, cur_d;
  logic [UW-1:0] used_q, used_d, iss_q, iss_d;
  logic          rdv_q, rdv_d, hit_q, hit_d;
  logic [AW-1:0] rdi_q, rdi_d, slot_q, slot_d;
  logic          out_valid_q, out_valid_d;
  gpd_out_t      out_q, out_d;

  logic          rd_en, mem_we;
  logic [AW-1:0] rd_addr, mem_wa;
  logic [MW-1:0] mem_wd;

  logic [GRID_BITS-1:0]  rd_x, rd_y, cur_gx, cur_gy;
  logic [COUNT_BITS-1:0] rd_c, sat_c;
  logic [SW-1:0]         sum;
  logic                  match;

  always_comb begin
    rd_x   = rd_data_q[MW-1 -: GRID_BITS];
    rd_y   = rd_data_q[COUNT_BITS +: GRID_BITS];
    rd_c   = rd_data_q[COUNT_BITS-1:0];
    cur_gx = cur_q.gx[GRID_BITS-1:0];
    cur_gy = cur_q.gy[GRID_BITS-1:0];
    match  = rdv_q && (rd_x == cur_gx) && (rd_y == cur_gy);
    sum    = (hit_q ? SW'(rd_c) : SW'(0)) + SW'(cur_q.trace_count);
    sat_c  = (sum > CMAX) ? CMAX[COUNT_BITS-1:0] : sum[COUNT_BITS-1:0];
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    used_d      = used_q;
    iss_d       = iss_q;
    rdv_d       = rdv_q;
    hit_d       = hit_q;
    rdi_d       = rdi_q;
    slot_d      = slot_q;
    q_pop_o     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = iss_q[AW-1:0];
    mem_we      = 1'b0;
    mem_wa      = slot_q;
    mem_wd      = {cur_gx, cur_gy, sat_c};
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_data_i;
          if (q_data_i.start) used_d = '0;
          iss_d   = '0;
          rdv_d   = 1'b0;
          hit_d   = 1'b0;
          state_d = q_data_i.in_aper ? B_SCAN : B_DONE;
        end
      end
      B_SCAN: begin
        if (match) begin
          hit_d   = 1'b1;
          slot_d  = rdi_q;
          rdv_d   = 1'b0;
          state_d = B_DONE;
        end else if (iss_q < used_q) begin
          rd_en = 1'b1;
          rdi_d = iss_q[AW-1:0];
          rdv_d = 1'b1;
          iss_d = iss_q + UW'(1);
        end else begin
          rdv_d   = 1'b0;
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_d.inside_aperture = cur_q.in_aper;
          out_d.added_new       = 1'b0;
          out_d.table_full      = 1'b0;
          out_d.off_grid        = cur_q.off_grid;
          out_d.slot            = '0;
          out_d.grid_x          = 12'(cur_gx);
          out_d.grid_y          = 12'(cur_gy);
          out_d.list_size       = 11'(used_q);
          out_d.slot_count      = '0;
          if (cur_q.in_aper) begin
            if (hit_q) begin
              mem_we           = 1'b1;
              out_d.slot       = 10'(slot_q);
              out_d.slot_count = 24'(sat_c);
            end else if (used_q != UMAX) begin
              mem_we           = 1'b1;
              mem_wa           = used_q[AW-1:0];
              used_d           = used_q + UW'(1);
              out_d.added_new  = 1'b1;
              out_d.slot       = 10'(used_q[AW-1:0]);
              out_d.list_size  = 11'(used_q + UW'(1));
              out_d.slot_count = 24'(sat_c);
            end else begin
              out_d.table_full = 1'b1;
            end
          end
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      used_q      <= '0;
      iss_q       <= '0;
      rdv_q       <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      iss_q       <= iss_d;
      rdv_q       <= rdv_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    rdi_q  <= rdi_d;
    slot_q <= slot_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (rd_en)  rd_data_q <= mem_q[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UMAX) else $error("list size overrun");
  a_read_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SCAN && rdv_q) |-> ({1'b0, rdi_q} < {1'b0, used_q}))
    else $error("compare against entry beyond list");
  a_hit_in_aper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DONE && hit_q) |-> cur_q.in_aper) else $error("hit outside aperture");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.added_new && out_q.table_full))
    else $error("added and full together");

endmodule

@@ design/grid_position_dedup_unit.sv @@
`timescale 1ns / 1ps
// Top level of the grid position de-duplication block: register file and wiring.
// Depends on gpd_pkg, gpd_front, gpd_queue and gpd_back.
//
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_stall_o    | in_data_i  (gpd_in_t)
//  out     | output    | out_valid_o / out_stall_i  | out_data_o (gpd_out_t)
//  config  | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// Front end steps each shot through aperture test, two multiplies on one multiplier and
// rounding, and stalls its input until the shot is pushed. Back end scans the list for each
// shot in the aperture on the single-port list (one entry a cycle); other shots skip the scan.
// A two-entry queue lets the front take the next shot while the back scans.
// Reset clears the list size and all control state; list contents need no clearing.
// A stalled output holds its result; the back end waits, and the front then fills the queue.
module grid_position_dedup_unit import gpd_pkg::*; #(
  parameter int unsigned MAX_POSITIONS = 1024,
  parameter int unsigned GRID_BITS     = 12,
  parameter int unsigned COUNT_BITS    = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gpd_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gpd_out_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  gpd_cfg_t cfg_q;
  gpd_reg_e reg_sel;
  logic     cfg_we;
  logic     q_push, q_pop, q_full, q_empty;
  gpd_cls_t q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign reg_sel = gpd_reg_e'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.aperture_lo_x <= '0;
      cfg_q.aperture_hi_x <= '0;
      cfg_q.aperture_lo_y <= '0;
      cfg_q.aperture_hi_y <= '0;
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
      cfg_q.inv_step_x    <= 32'h0100_0000;
      cfg_q.inv_step_y    <= 32'h0100_0000;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_APERTURE_LO_X: cfg_q.aperture_lo_x <= pwdata;
        REG_APERTURE_HI_X: cfg_q.aperture_hi_x <= pwdata;
        REG_APERTURE_LO_Y: cfg_q.aperture_lo_y <= pwdata;
        REG_APERTURE_HI_Y: cfg_q.aperture_hi_y <= pwdata;
        REG_ORIGIN_X:      cfg_q.origin_x      <= pwdata;
        REG_ORIGIN_Y:      cfg_q.origin_y      <= pwdata;
        REG_INV_STEP_X:    cfg_q.inv_step_x    <= pwdata;
        REG_INV_STEP_Y:    cfg_q.inv_step_y    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_APERTURE_LO_X: prdata = cfg_q.aperture_lo_x;
      REG_APERTURE_HI_X: prdata = cfg_q.aperture_hi_x;
      REG_APERTURE_LO_Y: prdata = cfg_q.aperture_lo_y;
      REG_APERTURE_HI_Y: prdata = cfg_q.aperture_hi_y;
      REG_ORIGIN_X:      prdata = cfg_q.origin_x;
      REG_ORIGIN_Y:      prdata = cfg_q.origin_y;
      REG_INV_STEP_X:    prdata = cfg_q.inv_step_x;
      REG_INV_STEP_Y:    prdata = cfg_q.inv_step_y;
      default:           prdata = '0;
    endcase
  end

  gpd_front #(
    .GRID_BITS (GRID_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .q_full_i   (q_full)
  );

  gpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  gpd_back #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .GRID_BITS     (GRID_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
